@@ hw/rtl/mbr_pkg.sv @@
// mbr_pkg: shared constants, request codes and transfer types of the msb-first bit reader
// used by mbr_fifo, mbr_front, mbr_back and msb_first_bit_reader; depends on nothing
`default_nettype none

package mbr_pkg;

    localparam int BUFFER_BYTES_DEFAULT = 4096;
    localparam int MAX_BITS             = 32;
    localparam int WORD_W               = 32;
    localparam int QUEUE_DEPTH          = 2;

    localparam int          LEN_REG_W = 13;
    localparam logic [12:0] LEN_RESET = 13'd4096;

    // register index on the configuration port
    localparam logic REG_BUFFER_LENGTH = 1'b0;

    // request codes on req_type
    localparam logic [2:0] REQ_WRITE   = 3'd0;
    localparam logic [2:0] REQ_RESTART = 3'd1;
    localparam logic [2:0] REQ_READ    = 3'd2;
    localparam logic [2:0] REQ_PEEK    = 3'd3;
    localparam logic [2:0] REQ_SKIP    = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WRITE,
        OP_RESTART,
        OP_READ,
        OP_PEEK,
        OP_SKIP
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [11:0] byte_address;
        logic [7:0]  byte_value;
        logic [5:0]  bit_count;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0] bits_value;
        logic              at_end;
    } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/mbr_fifo.sv @@
// mbr_fifo: small synchronous queue with push/full and pop/empty sides
// depends on mbr_pkg for the default depth
`default_nettype none

module mbr_fifo
    import mbr_pkg::*;
#(
    parameter int W     = 1,
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] wr_data,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      rd_data,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mbr_front.sv @@
// mbr_front: takes request transfers, decodes the request code, clamps the bit count
// and queues the command for the back end; depends on mbr_pkg and mbr_fifo
`default_nettype none

module mbr_front
    import mbr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  req_type,
    input  wire logic [11:0] byte_address,
    input  wire logic [7:0]  byte_value,
    input  wire logic [5:0]  bit_count,
    input  wire logic        cmd_pop,
    output cmd_t             cmd,
    output logic             cmd_empty
);

    cmd_t decoded;

    always_comb
    begin
        decoded.byte_address = byte_address;
        decoded.byte_value   = byte_value;
        decoded.bit_count    = (32'(bit_count) > MAX_BITS) ? 6'(MAX_BITS) : bit_count;
        case (req_type)
            REQ_WRITE:   decoded.op = OP_WRITE;
            REQ_RESTART: decoded.op = OP_RESTART;
            REQ_READ:    decoded.op = OP_READ;
            REQ_PEEK:    decoded.op = OP_PEEK;
            REQ_SKIP:    decoded.op = OP_SKIP;
            default:     decoded.op = OP_NOP;
        endcase
    end

    mbr_fifo #(
        .W     ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (decoded),
        .full    (full),
        .pop     (cmd_pop),
        .rd_data (cmd),
        .empty   (cmd_empty)
    );

endmodule

`default_nettype wire

@@ hw/rtl/mbr_back.sv @@
// mbr_back: executes queued commands against the byte store and the bit pointer,
// extracts bit fields from a two-word window and queues results; depends on mbr_pkg, mbr_fifo
`default_nettype none

module mbr_back
    import mbr_pkg::*;
#(
    parameter  int BUFFER_BYTES = BUFFER_BYTES_DEFAULT,
    localparam int LEN_W        = $clog2(BUFFER_BYTES + 1)
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_t             cmd,
    input  wire logic             cmd_empty,
    output logic                  cmd_pop,
    input  wire logic [LEN_W-1:0] eff_len,
    input  wire logic             pop,
    output logic                  empty,
    output res_t                  res
);

    localparam int WORDS     = (BUFFER_BYTES + 3) / 4;
    localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int MEM_WORDS = 1 << WA_W;
    localparam int BP_W      = LEN_W + 3;

    typedef enum logic [1:0] {
        S_ISSUE = 2'b01,
        S_EXEC  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [BP_W-1:0] bp_reg, bp_next;

    op_t         op_reg;
    logic [5:0]  count_reg;
    logic [5:0]  n_valid_reg;
    logic [6:0]  rshift_reg;
    logic        past_reg;
    logic        reach_end_reg;
    logic [WORD_W-1:0] word0_reg;
    logic [WORD_W-1:0] word1_reg;

    logic [WORD_W-1:0] store_mem [MEM_WORDS];

    logic [BP_W-1:0] end_bits;
    logic [BP_W:0]   diff;
    logic            past;
    logic            short_avail;
    logic            reach_end;
    logic [5:0]      n_valid;
    logic [6:0]      rshift;
    logic            start;
    logic [WA_W-1:0] ra0;
    logic [WA_W-1:0] ra1;
    logic [WA_W-1:0] wa;
    logic [1:0]      lane_inv;
    logic            wr_ok;

    logic [2*WORD_W-1:0] window;
    logic [2*WORD_W-1:0] shifted;
    logic [WORD_W-1:0]   keep;
    logic [WORD_W-1:0]   data;
    logic                end_flag;
    logic                res_push;
    logic                res_full;
    res_t                res_in;

    function automatic logic [WORD_W-1:0] low_ones(input logic [5:0] k);
        logic [WORD_W:0] full_mask;
        full_mask = ((WORD_W + 1)'(1) << k) - (WORD_W + 1)'(1);
        return full_mask[WORD_W-1:0];
    endfunction

    // issue side: position arithmetic and store addressing
    always_comb
    begin
        end_bits    = {eff_len, 3'b000};
        diff        = {1'b0, end_bits} - {1'b0, bp_reg};
        past        = diff[BP_W] || (diff == '0);
        short_avail = 32'(diff[BP_W-1:0]) < 32'(cmd.bit_count);
        reach_end   = !past && !(32'(diff[BP_W-1:0]) > 32'(cmd.bit_count));
        if (past)
        begin
            n_valid = '0;
        end
        else if (short_avail)
        begin
            n_valid = 6'(diff[BP_W-1:0]);
        end
        else
        begin
            n_valid = cmd.bit_count;
        end
        rshift   = 7'd64 - 7'(bp_reg[4:0]) - 7'(cmd.bit_count);
        ra0      = WA_W'(bp_reg >> 5);
        ra1      = ra0 + 1'b1;
        wa       = WA_W'(cmd.byte_address >> 2);
        lane_inv = ~cmd.byte_address[1:0];
        wr_ok    = 32'(cmd.byte_address) < BUFFER_BYTES;
        start    = (state_reg == S_ISSUE) && !cmd_empty && !res_full;
    end

    assign cmd_pop = start;

    // exec side: field extraction and end flag
    always_comb
    begin
        window  = {word0_reg, word1_reg};
        shifted = window >> rshift_reg;
        keep    = low_ones(count_reg) & ~low_ones(count_reg - n_valid_reg);
        if (op_reg == OP_READ || op_reg == OP_PEEK)
        begin
            data = shifted[WORD_W-1:0] & keep;
        end
        else
        begin
            data = '0;
        end
        case (op_reg)
            OP_RESTART:      end_flag = 1'b0;
            OP_READ,
            OP_SKIP:         end_flag = past_reg || reach_end_reg;
            default:         end_flag = past_reg;
        endcase
        res_push          = (state_reg == S_EXEC);
        res_in.bits_value = data;
        res_in.at_end     = end_flag;
    end

    always_comb
    begin
        state_next = state_reg;
        bp_next    = bp_reg;
        case (state_reg)
            S_ISSUE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_ISSUE;
                if (op_reg == OP_RESTART)
                begin
                    bp_next = '0;
                end
                else if (op_reg == OP_READ || op_reg == OP_SKIP)
                begin
                    bp_next = bp_reg + BP_W'(n_valid_reg);
                end
            end
            default:
            begin
                state_next = S_ISSUE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ISSUE;
            bp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bp_reg    <= bp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg        <= cmd.op;
            count_reg     <= cmd.bit_count;
            n_valid_reg   <= n_valid;
            rshift_reg    <= rshift;
            past_reg      <= past;
            reach_end_reg <= reach_end;
        end
    end

    // byte store: 32-bit words, first byte in the top lane
    always_ff @(posedge clk)
    begin
        if (start && cmd.op == OP_WRITE && wr_ok)
        begin
            store_mem[wa][{lane_inv, 3'b000} +: 8] <= cmd.byte_value;
        end
        if (start)
        begin
            word0_reg <= store_mem[ra0];
            word1_reg <= store_mem[ra1];
        end
    end

    mbr_fifo #(
        .W     ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res),
        .empty   (empty)
    );

    a_bp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(bp_reg) <= 8 * BUFFER_BYTES)
        else $error("bit pointer beyond buffer");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && (op_reg == OP_READ || op_reg == OP_SKIP)
        |=> bp_reg == $past(bp_reg) + BP_W'($past(n_valid_reg)))
        else $error("bit pointer did not advance by consumed bits");

    a_peek_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && (op_reg == OP_PEEK || op_reg == OP_WRITE) |=> $stable(bp_reg))
        else $error("peek or write moved the bit pointer");

    a_no_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && (n_valid_reg == '0) |-> res_in.bits_value == '0)
        else $error("nonzero field with no bits taken");

endmodule

`default_nettype wire

@@ hw/rtl/msb_first_bit_reader.sv @@
// msb_first_bit_reader: top level, configuration register and front/back wiring
// depends on mbr_pkg, mbr_front, mbr_back
//
// Usage: requests enter through push/full; one transfer is one request (write byte,
// restart, read, peek or skip of 0 to 32 bits). Every request gives exactly one result
// transfer on empty/pop: bits_value (msb-first field, right aligned, zero unless read or
// peek) and at_end (all valid bits consumed after the request).
// The byte store is loaded with write byte requests; buffer_length (APB register 0,
// byte address 0) sets how many leading bytes are valid; the user must see that it is
// written only while idle, the block itself does not enforce it. A request accepted
// into the command queue is popped by the back end, which registers two store words;
// the execute state then shifts the 64-bit window, masks and writes the result into
// the result queue. The back end takes no new request until the last has executed,
// through its issue/execute loop on the shared bit pointer and the two store read ports.
// Reset clears the bit pointer to byte 0, bit 7, empties both queues and sets
// buffer_length to 4096; the byte store holds garbage until written, no clearing pass.
// When the receiver stalls the result queue fills, the back end stops, then the command
// queue fills and full rises; nothing is dropped.
`default_nettype none

module msb_first_bit_reader
    import mbr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  req_type,
    input  wire logic [11:0] byte_address,
    input  wire logic [7:0]  byte_value,
    input  wire logic [5:0]  bit_count,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      bits_value,
    output logic             at_end,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int LEN_W         = $clog2(BUFFER_BYTES + 1);
    localparam int EFF_RESET_INT = (int'(LEN_RESET) > BUFFER_BYTES) ? BUFFER_BYTES
                                                                  : int'(LEN_RESET);

    logic [LEN_REG_W-1:0] buffer_length_reg, buffer_length_next;
    logic [LEN_W-1:0]     eff_len_reg, eff_len_next;
    logic                 cfg_write;
    logic [LEN_REG_W-1:0] wr_len;

    cmd_t cmd;
    logic cmd_empty;
    logic cmd_pop;
    res_t res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_BUFFER_LENGTH);
    assign wr_len    = pwdata[LEN_REG_W-1:0];
    assign prdata    = (paddr[2] == REG_BUFFER_LENGTH) ? 32'(buffer_length_reg) : '0;

    // clamp the length once at write time
    always_comb
    begin
        buffer_length_next = buffer_length_reg;
        eff_len_next       = eff_len_reg;
        if (cfg_write)
        begin
            buffer_length_next = wr_len;
            if (wr_len == '0)
            begin
                eff_len_next = LEN_W'(1);
            end
            else if (32'(wr_len) > BUFFER_BYTES)
            begin
                eff_len_next = LEN_W'(BUFFER_BYTES);
            end
            else
            begin
                eff_len_next = LEN_W'(wr_len);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_length_reg <= LEN_RESET;
            eff_len_reg       <= LEN_W'(EFF_RESET_INT);
        end
        else
        begin
            buffer_length_reg <= buffer_length_next;
            eff_len_reg       <= eff_len_next;
        end
    end

    mbr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .byte_address (byte_address),
        .byte_value   (byte_value),
        .bit_count    (bit_count),
        .cmd_pop      (cmd_pop),
        .cmd          (cmd),
        .cmd_empty    (cmd_empty)
    );

    mbr_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .eff_len   (eff_len_reg),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign bits_value = res.bits_value;
    assign at_end     = res.at_end;

endmodule

`default_nettype wire
